[rtl/core/rcg_pkg.sv]
// ----------------------------------------------------------------------------
// rcg_pkg
// Shared types, constants, microcode program and generator functions for the
// RLC coding coefficient generator.
// ----------------------------------------------------------------------------
package rcg_pkg;

   localparam int KEY_W        = 16;
   localparam int COUNT_W      = 7;
   localparam int COEF_W       = 8;
   localparam int STATUS_W     = 2;
   localparam int CFG_W        = 4;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int MAX_WINDOW_DEFAULT = 64;

   localparam logic [31:0] TMT_MAT1  = 32'h8f70_11ee;
   localparam logic [31:0] TMT_MAT2  = 32'hfc78_ff1f;
   localparam logic [31:0] TMT_TMAT  = 32'h3793_fdff;
   localparam logic [31:0] SEED_MULT = 32'd1812433253;
   localparam logic [31:0] TINY_T    = 32'd84;
   localparam logic [31:0] TINY_I    = 32'd73;
   localparam logic [31:0] TINY_N    = 32'd78;
   localparam logic [31:0] TINY_Y    = 32'd89;

   localparam logic [CFG_W-1:0] DENSITY_FULL  = 4'd15;
   localparam logic [CFG_W-1:0] DEGREE_GF2    = 4'd1;
   localparam logic [CFG_W-1:0] DEGREE_GF256  = 4'd8;
   localparam logic [CFG_W-1:0] DENSITY_RESET = 4'd15;
   localparam logic [CFG_W-1:0] DEGREE_RESET  = 4'd8;

   localparam logic REG_DENSITY      = 1'b0;
   localparam logic REG_FIELD_DEGREE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_DEGREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;

   localparam logic [3:0] SEED_ROUNDS  = 4'd7;
   localparam logic [3:0] WARMUP_STEPS = 4'd8;

   typedef logic [3:0][31:0] words_type;
   typedef logic [4:0]       pc_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_SEED,
      DP_MUL,
      DP_MIX,
      DP_FIX,
      DP_NEXT,
      DP_DRAW
   } dp_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_LOAD,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_DISPATCH,
      C_CNT_MORE,
      C_DENSE,
      C_GF2,
      C_REJECT,
      C_BYTE_ZERO
   } cond_type;

   typedef enum logic [2:0] {
      EM_NONE,
      EM_ERR_DEGREE,
      EM_ERR_EMPTY,
      EM_ONE,
      EM_ZERO,
      EM_BYTE
   } emit_type;

   typedef struct packed {
      logic       accept;
      dp_op_type  dp_op;
      cnt_op_type cnt_op;
      logic [3:0] cnt_load;
      cond_type   cond;
      pc_type     target;
      emit_type   emit;
   } ctrl_word_type;

   typedef struct packed {
      logic [7:0] rand256;
      logic [3:0] rand16;
      logic       rand_zero;
   } flags_type;

   typedef struct packed {
      logic      accept;
      dp_op_type dp_op;
      logic      emit_fire;
      emit_type  emit;
      logic      last;
   } seq_out_type;

   localparam pc_type P_IDLE      = 5'd0;
   localparam pc_type P_ERR_DEG   = 5'd1;
   localparam pc_type P_ERR_EMPTY = 5'd2;
   localparam pc_type P_ONES      = 5'd3;
   localparam pc_type P_SEED      = 5'd4;
   localparam pc_type P_MUL       = 5'd5;
   localparam pc_type P_MIX       = 5'd6;
   localparam pc_type P_FIX       = 5'd7;
   localparam pc_type P_WARM      = 5'd8;
   localparam pc_type P_COEF      = 5'd9;
   localparam pc_type P_THR_DRAW  = 5'd10;
   localparam pc_type P_THR_TEST  = 5'd11;
   localparam pc_type P_FIELD     = 5'd12;
   localparam pc_type P_NZ_DRAW   = 5'd13;
   localparam pc_type P_NZ_TEST   = 5'd14;
   localparam pc_type P_EMIT_BYTE = 5'd15;
   localparam pc_type P_EMIT_ZERO = 5'd16;
   localparam pc_type P_EMIT_ONE  = 5'd17;

   function automatic ctrl_word_type uop(logic accept, dp_op_type dp_op,
                                         cnt_op_type cnt_op, logic [3:0] cnt_load,
                                         cond_type cond, pc_type target,
                                         emit_type emit);
      ctrl_word_type cw;
      cw.accept   = accept;
      cw.dp_op    = dp_op;
      cw.cnt_op   = cnt_op;
      cw.cnt_load = cnt_load;
      cw.cond     = cond;
      cw.target   = target;
      cw.emit     = emit;
      return cw;
   endfunction

   function automatic ctrl_word_type ucode_rom(pc_type pc);
      ctrl_word_type cw;
      unique case (pc)
         P_IDLE:      cw = uop(1'b1, DP_NOP, CNT_HOLD, 4'd0, C_DISPATCH, P_IDLE, EM_NONE);
         P_ERR_DEG:   cw = uop(1'b0, DP_NOP, CNT_HOLD, 4'd0, C_NEXT, P_IDLE, EM_ERR_DEGREE);
         P_ERR_EMPTY: cw = uop(1'b0, DP_NOP, CNT_HOLD, 4'd0, C_NEXT, P_IDLE, EM_ERR_EMPTY);
         P_ONES:      cw = uop(1'b0, DP_NOP, CNT_HOLD, 4'd0, C_ALWAYS, P_ONES, EM_ONE);
         P_SEED:      cw = uop(1'b0, DP_SEED, CNT_LOAD, SEED_ROUNDS, C_NEXT, P_IDLE,
                               EM_NONE);
         P_MUL:       cw = uop(1'b0, DP_MUL, CNT_HOLD, 4'd0, C_NEXT, P_IDLE, EM_NONE);
         P_MIX:       cw = uop(1'b0, DP_MIX, CNT_DEC, 4'd0, C_CNT_MORE, P_MUL, EM_NONE);
         P_FIX:       cw = uop(1'b0, DP_FIX, CNT_LOAD, WARMUP_STEPS, C_NEXT, P_IDLE,
                               EM_NONE);
         P_WARM:      cw = uop(1'b0, DP_NEXT, CNT_DEC, 4'd0, C_CNT_MORE, P_WARM, EM_NONE);
         P_COEF:      cw = uop(1'b0, DP_NOP, CNT_HOLD, 4'd0, C_DENSE, P_FIELD, EM_NONE);
         P_THR_DRAW:  cw = uop(1'b0, DP_DRAW, CNT_HOLD, 4'd0, C_NEXT, P_IDLE, EM_NONE);
         P_THR_TEST:  cw = uop(1'b0, DP_NOP, CNT_HOLD, 4'd0, C_REJECT, P_EMIT_ZERO,
                               EM_NONE);
         P_FIELD:     cw = uop(1'b0, DP_NOP, CNT_HOLD, 4'd0, C_GF2, P_EMIT_ONE, EM_NONE);
         P_NZ_DRAW:   cw = uop(1'b0, DP_DRAW, CNT_HOLD, 4'd0, C_NEXT, P_IDLE, EM_NONE);
         P_NZ_TEST:   cw = uop(1'b0, DP_NOP, CNT_HOLD, 4'd0, C_BYTE_ZERO, P_NZ_DRAW,
                               EM_NONE);
         P_EMIT_BYTE: cw = uop(1'b0, DP_NOP, CNT_HOLD, 4'd0, C_ALWAYS, P_COEF, EM_BYTE);
         P_EMIT_ZERO: cw = uop(1'b0, DP_NOP, CNT_HOLD, 4'd0, C_ALWAYS, P_COEF, EM_ZERO);
         P_EMIT_ONE:  cw = uop(1'b0, DP_NOP, CNT_HOLD, 4'd0, C_ALWAYS, P_COEF, EM_ONE);
         default:     cw = uop(1'b0, DP_NOP, CNT_HOLD, 4'd0, C_ALWAYS, P_IDLE, EM_NONE);
      endcase
      return cw;
   endfunction

   // one TinyMT32 state transition
   function automatic words_type tmt_next(words_type w);
      logic [31:0] x;
      logic [31:0] y;
      words_type   n;
      y = w[3];
      x = (w[0] & 32'h7fff_ffff) ^ w[1] ^ w[2];
      x = x ^ (x << 1);
      y = y ^ (y >> 1) ^ x;
      n[0] = w[1];
      n[1] = w[2];
      n[2] = x ^ (y << 10);
      n[3] = y;
      if (y[0]) begin
         n[1] = n[1] ^ TMT_MAT1;
         n[2] = n[2] ^ TMT_MAT2;
      end
      return n;
   endfunction

   // low byte of the tempered output
   function automatic logic [7:0] tmt_temper8(words_type w);
      logic [31:0] t0;
      logic [31:0] t1;
      t1 = w[0] + (w[2] >> 8);
      t0 = w[3] ^ t1;
      if (t1[0]) begin
         t0 = t0 ^ TMT_TMAT;
      end
      return t0[7:0];
   endfunction

endpackage

[rtl/core/rcg_if.sv]
// ----------------------------------------------------------------------------
// rcg_if
// Request and response channel interfaces of the coefficient generator.
// ----------------------------------------------------------------------------
interface rcg_req_if;
   logic                        valid;
   logic                        ready;
   logic [rcg_pkg::KEY_W-1:0]   coding_key;
   logic [rcg_pkg::COUNT_W-1:0] coef_count;

   modport source (output valid, output coding_key, output coef_count, input ready);
   modport sink   (input valid, input coding_key, input coef_count, output ready);
endinterface

interface rcg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rcg_pkg::COEF_W-1:0]   coefficient;
   logic                         last;
   logic [rcg_pkg::STATUS_W-1:0] status;

   modport source (output valid, output coefficient, output last, output status,
                   input ready);
   modport sink   (input valid, input coefficient, input last, input status,
                   output ready);
endinterface

[rtl/core/rcg_datapath.sv]
// ----------------------------------------------------------------------------
// rcg_datapath
// TinyMT32 state words, seeding multiplier and tempering, driven by one
// micro-operation per cycle.
// ----------------------------------------------------------------------------
module rcg_datapath (
   input  logic                      clock,
   input  rcg_pkg::dp_op_type        dp_op,
   input  logic [rcg_pkg::KEY_W-1:0] key,
   output rcg_pkg::flags_type        flags
);
   import rcg_pkg::*;

   words_type   words_ff;
   words_type   words_in;
   logic [31:0] mul_ff;
   logic [31:0] mul_in;
   logic [2:0]  idx_ff;
   logic [2:0]  idx_in;
   logic [7:0]  draw_ff;
   logic [7:0]  draw_in;

   words_type   mixed;
   words_type   rot_mixed;
   words_type   rot_plain;
   words_type   stepped;
   logic [31:0] p_mix;
   logic        all_zero;

   assign p_mix     = words_ff[0] ^ (words_ff[0] >> 30);
   assign stepped   = tmt_next(words_ff);
   assign rot_plain = {words_ff[0], words_ff[3], words_ff[2], words_ff[1]};
   assign all_zero  = ((rot_plain[0] & 32'h7fff_ffff) == 32'd0) &&
                      (rot_plain[1] == 32'd0) && (rot_plain[2] == 32'd0) &&
                      (rot_plain[3] == 32'd0);

   always_comb begin
      mixed    = words_ff;
      mixed[1] = words_ff[1] ^ ({29'd0, idx_ff} + mul_ff);
   end

   assign rot_mixed = {mixed[0], mixed[3], mixed[2], mixed[1]};

   always_comb begin
      words_in = words_ff;
      mul_in   = mul_ff;
      idx_in   = idx_ff;
      draw_in  = draw_ff;
      unique case (dp_op)
         DP_NOP: begin
         end
         DP_SEED: begin
            words_in = {TMT_TMAT, TMT_MAT2, TMT_MAT1, {16'd0, key}};
            idx_in   = 3'd1;
         end
         DP_MUL: begin
            mul_in = SEED_MULT * p_mix;
         end
         DP_MIX: begin
            words_in = rot_mixed;
            idx_in   = idx_ff + 3'd1;
         end
         DP_FIX: begin
            words_in = all_zero ? {TINY_Y, TINY_N, TINY_I, TINY_T} : rot_plain;
         end
         DP_NEXT: begin
            words_in = stepped;
         end
         DP_DRAW: begin
            words_in = stepped;
            draw_in  = tmt_temper8(stepped);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
      mul_ff   <= mul_in;
      idx_ff   <= idx_in;
      draw_ff  <= draw_in;
   end

   assign flags.rand256   = draw_ff;
   assign flags.rand16    = draw_ff[3:0];
   assign flags.rand_zero = (draw_ff == 8'd0);

endmodule

[rtl/core/rcg_sequencer.sv]
// ----------------------------------------------------------------------------
// rcg_sequencer
// Microcode step counter, loop counter and coefficient count; fetches one
// control word per cycle, holding it on a stall, and resolves conditional jumps.
// ----------------------------------------------------------------------------
module rcg_sequencer #(
   parameter int MAX_WINDOW = rcg_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [rcg_pkg::COUNT_W-1:0] req_count,
   input  logic                        rsp_busy,
   input  logic [rcg_pkg::CFG_W-1:0]   density,
   input  logic [rcg_pkg::CFG_W-1:0]   field_degree,
   input  rcg_pkg::flags_type          flags,
   output rcg_pkg::seq_out_type        seq_out
);
   import rcg_pkg::*;

   localparam int REM_W = $clog2(MAX_WINDOW + 1);

   pc_type           pc_ff;
   pc_type           pc_in;
   logic [3:0]       cnt_ff;
   logic [3:0]       cnt_in;
   logic [REM_W-1:0] remaining_ff;
   logic [REM_W-1:0] remaining_in;

   ctrl_word_type    ctrl;
   logic             stall;
   logic             cond_true;
   logic             is_error;
   logic             last;
   logic             emitting;
   logic             gf2;
   logic             dense;
   pc_type           dispatch_pc;
   logic [REM_W-1:0] sat_count;

   assign ctrl     = ucode_rom(pc_ff);
   assign gf2      = (field_degree == DEGREE_GF2);
   assign dense    = (density == DENSITY_FULL);
   assign emitting = (ctrl.emit != EM_NONE);
   assign stall    = (ctrl.accept && !req_valid) || (emitting && rsp_busy);
   assign is_error = (ctrl.emit == EM_ERR_DEGREE) || (ctrl.emit == EM_ERR_EMPTY);
   assign last     = is_error || (remaining_ff == REM_W'(1));

   assign sat_count = (req_count > COUNT_W'(MAX_WINDOW)) ? REM_W'(MAX_WINDOW) :
                                                          req_count[REM_W-1:0];

   always_comb begin
      priority if ((field_degree != DEGREE_GF2) && (field_degree != DEGREE_GF256)) begin
         dispatch_pc = P_ERR_DEG;
      end else if (req_count == '0) begin
         dispatch_pc = P_ERR_EMPTY;
      end else if (gf2 && dense) begin
         dispatch_pc = P_ONES;
      end else begin
         dispatch_pc = P_SEED;
      end
   end

   always_comb begin
      unique case (ctrl.cond)
         C_NEXT:      cond_true = 1'b0;
         C_ALWAYS:    cond_true = 1'b1;
         C_DISPATCH:  cond_true = 1'b1;
         C_CNT_MORE:  cond_true = (cnt_ff != 4'd1);
         C_DENSE:     cond_true = dense;
         C_GF2:       cond_true = gf2;
         C_REJECT:    cond_true = (flags.rand16 > density);
         C_BYTE_ZERO: cond_true = flags.rand_zero;
      endcase
   end

   always_comb begin
      priority if (stall) begin
         pc_in = pc_ff;
      end else if (emitting && last) begin
         pc_in = P_IDLE;
      end else if (ctrl.cond == C_DISPATCH) begin
         pc_in = dispatch_pc;
      end else if (cond_true) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + 5'd1;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (!stall) begin
         unique case (ctrl.cnt_op)
            CNT_HOLD: cnt_in = cnt_ff;
            CNT_LOAD: cnt_in = ctrl.cnt_load;
            CNT_DEC:  cnt_in = cnt_ff - 4'd1;
            default:  cnt_in = cnt_ff;
         endcase
      end
   end

   always_comb begin
      remaining_in = remaining_ff;
      if (ctrl.accept && req_valid) begin
         remaining_in = sat_count;
      end else if (emitting && !stall && !is_error) begin
         remaining_in = remaining_ff - REM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= P_IDLE;
         cnt_ff       <= '0;
         remaining_ff <= '0;
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         remaining_ff <= remaining_in;
      end
   end

   assign seq_out.accept    = ctrl.accept;
   assign seq_out.dp_op     = stall ? DP_NOP : ctrl.dp_op;
   assign seq_out.emit_fire = emitting && !stall;
   assign seq_out.emit      = ctrl.emit;
   assign seq_out.last      = last;

endmodule

[rtl/core/rlc_coding_coefficient_generator.sv]
// ----------------------------------------------------------------------------
// rlc_coding_coefficient_generator
// An error result is issued from an error step once its request is accepted;
// GF(2) at full density issues one coefficient per cycle unless the output
// stalls. Else the state is seeded and warmed up, and each coefficient may be
// rejected to 0 below full density, else is 1 (GF(2)) or a non-zero byte.
// Throughput: a new request is taken the cycle after the final result issues.
// Reset: sequencer idle, output empty, density 15, field degree 8.
// ----------------------------------------------------------------------------
module rlc_coding_coefficient_generator #(
   parameter int MAX_WINDOW = rcg_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   rcg_req_if.sink                        req,
   rcg_rsp_if.source                      rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rcg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rcg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rcg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import rcg_pkg::*;

   logic [CFG_W-1:0]    density_ff;
   logic [CFG_W-1:0]    density_in;
   logic [CFG_W-1:0]    degree_ff;
   logic [CFG_W-1:0]    degree_in;
   logic [KEY_W-1:0]    key_ff;
   logic [KEY_W-1:0]    key_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [COEF_W-1:0]   coef_ff;
   logic [COEF_W-1:0]   coef_in;
   logic                last_ff;
   logic                last_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;

   logic                csr_write;
   logic                req_fire;
   logic                rsp_busy;
   seq_out_type         seq_out;
   flags_type           flags;
   logic [COEF_W-1:0]   emit_coef;
   logic [STATUS_W-1:0] emit_status;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      density_in = density_ff;
      degree_in  = degree_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_DENSITY:      density_in = csr_pwdata[CFG_W-1:0];
            REG_FIELD_DEGREE: degree_in  = csr_pwdata[CFG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_DENSITY:      csr_prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, density_ff};
         REG_FIELD_DEGREE: csr_prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, degree_ff};
      endcase
   end

   // request side
   assign req.ready = seq_out.accept;
   assign req_fire  = req.valid && seq_out.accept;
   assign key_in    = req_fire ? req.coding_key : key_ff;
   assign rsp_busy  = rsp_valid_ff && !rsp.ready;

   rcg_sequencer #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req.valid),
      .req_count    (req.coef_count),
      .rsp_busy     (rsp_busy),
      .density      (density_ff),
      .field_degree (degree_ff),
      .flags        (flags),
      .seq_out      (seq_out)
   );

   rcg_datapath u_datapath (
      .clock (clock),
      .dp_op (seq_out.dp_op),
      .key   (key_ff),
      .flags (flags)
   );

   // result register
   always_comb begin
      unique case (seq_out.emit)
         EM_ERR_DEGREE: begin
            emit_coef   = 8'd0;
            emit_status = STATUS_BAD_DEGREE;
         end
         EM_ERR_EMPTY: begin
            emit_coef   = 8'd0;
            emit_status = STATUS_EMPTY;
         end
         EM_ONE: begin
            emit_coef   = 8'd1;
            emit_status = STATUS_OK;
         end
         EM_BYTE: begin
            emit_coef   = flags.rand256;
            emit_status = STATUS_OK;
         end
         default: begin
            emit_coef   = 8'd0;
            emit_status = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      coef_in      = coef_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      if (seq_out.emit_fire) begin
         rsp_valid_in = 1'b1;
         coef_in      = emit_coef;
         last_in      = seq_out.last;
         status_in    = emit_status;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         density_ff   <= DENSITY_RESET;
         degree_ff    <= DEGREE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         density_ff   <= density_in;
         degree_ff    <= degree_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      coef_ff   <= coef_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.coefficient = coef_ff;
   assign rsp.last        = last_ff;
   assign rsp.status      = status_ff;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RLC coding coefficient generator. Requests are
// fed from a queue with random gaps, results are taken with random stalls,
// and every coefficient is checked against a TinyMT32-based predictor
// that follows each density and field degree setting written over APB.
// ----------------------------------------------------------------------------
module tb;
   import rcg_pkg::*;

   localparam int GAP_PERCENT       = 15;
   localparam int RANDOM_SETTINGS   = 14;
   localparam int ITEMS_PER_SETTING = 30;
   localparam int END_QUIET_CYCLES  = 50;

   localparam logic [CSR_ADDR_W-1:0] ADDR_DENSITY      = {REG_DENSITY, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_FIELD_DEGREE = {REG_FIELD_DEGREE, 2'b00};

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] count;
   } request_type;

   typedef struct packed {
      logic [COEF_W-1:0]   coefficient;
      logic                last;
      logic [STATUS_W-1:0] status;
   } coef_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rcg_req_if req_ch ();
   rcg_rsp_if rsp_ch ();

   request_type     requests_to_send[$];
   coef_result_type coefs_due[$];

   logic [31:0]      mt_word[4];
   logic [CFG_W-1:0] cfg_density = DENSITY_RESET;
   logic [CFG_W-1:0] cfg_degree  = DEGREE_RESET;

   bit steady_flow = 1'b0;
   int errors_seen = 0;
   int n_requests  = 0;
   int n_coefs     = 0;
   int n_rejects   = 0;
   int n_settings  = 0;

   rlc_coding_coefficient_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // TinyMT32 predictor
   function automatic void mt_step();
      logic [31:0] x;
      logic [31:0] y;
      y = mt_word[3];
      x = (mt_word[0] & 32'h7fff_ffff) ^ mt_word[1] ^ mt_word[2];
      x = x ^ (x << 1);
      y = y ^ (y >> 1) ^ x;
      mt_word[0] = mt_word[1];
      mt_word[1] = mt_word[2];
      mt_word[2] = x ^ (y << 10);
      mt_word[3] = y;
      if (y[0]) begin
         mt_word[1] = mt_word[1] ^ TMT_MAT1;
         mt_word[2] = mt_word[2] ^ TMT_MAT2;
      end
   endfunction

   function automatic logic [31:0] mt_output();
      logic [31:0] sum;
      logic [31:0] mixed;
      mt_step();
      sum   = mt_word[0] + (mt_word[2] >> 8);
      mixed = mt_word[3] ^ sum;
      if (sum[0]) begin
         mixed = mixed ^ TMT_TMAT;
      end
      return mixed;
   endfunction

   function automatic void mt_seed(logic [KEY_W-1:0] key);
      logic [31:0] prev;
      mt_word[0] = {{(32-KEY_W){1'b0}}, key};
      mt_word[1] = TMT_MAT1;
      mt_word[2] = TMT_MAT2;
      mt_word[3] = TMT_TMAT;
      for (int unsigned i = 1; i < 8; i++) begin
         prev = mt_word[(i - 1) % 4];
         mt_word[i % 4] = mt_word[i % 4] ^ (i + SEED_MULT * (prev ^ (prev >> 30)));
      end
      if ((mt_word[0] & 32'h7fff_ffff) == 0 && mt_word[1] == 0 && mt_word[2] == 0 &&
          mt_word[3] == 0) begin
         mt_word[0] = TINY_T;
         mt_word[1] = TINY_I;
         mt_word[2] = TINY_N;
         mt_word[3] = TINY_Y;
      end
      for (int i = 0; i < 8; i++) begin
         mt_step();
      end
   endfunction

   function automatic logic [7:0] mt_nonzero_byte();
      logic [31:0] r;
      do begin
         r = mt_output();
      end while (r[7:0] == 8'h00);
      return r[7:0];
   endfunction

   function automatic logic mt_keep();
      logic [31:0] r;
      r = mt_output();
      return r[3:0] <= cfg_density;
   endfunction

   function automatic void predict_coefficients(logic [KEY_W-1:0] key,
                                                logic [COUNT_W-1:0] count);
      int          n;
      logic [7:0]  c;
      if (cfg_degree != DEGREE_GF2 && cfg_degree != DEGREE_GF256) begin
         coefs_due.push_back('{8'h00, 1'b1, STATUS_BAD_DEGREE});
         return;
      end
      if (count == 0) begin
         coefs_due.push_back('{8'h00, 1'b1, STATUS_EMPTY});
         return;
      end
      n = (count > MAX_WINDOW_DEFAULT) ? MAX_WINDOW_DEFAULT : int'(count);
      if (!(cfg_degree == DEGREE_GF2 && cfg_density == DENSITY_FULL)) begin
         mt_seed(key);
      end
      for (int i = 0; i < n; i++) begin
         if (cfg_degree == DEGREE_GF2) begin
            if (cfg_density == DENSITY_FULL) c = 8'd1;
            else c = mt_keep() ? 8'd1 : 8'd0;
         end else if (cfg_density == DENSITY_FULL) begin
            c = mt_nonzero_byte();
         end else if (mt_keep()) begin
            c = mt_nonzero_byte();
         end else begin
            c = 8'd0;
         end
         coefs_due.push_back('{c, (i == n - 1), STATUS_OK});
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.coding_key <= '0;
         req_ch.coef_count <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (requests_to_send.size() != 0 &&
             (steady_flow || $urandom_range(0, 99) >= GAP_PERCENT)) begin
            req_ch.valid      <= 1'b1;
            req_ch.coding_key <= requests_to_send[0].key;
            req_ch.coef_count <= requests_to_send[0].count;
            void'(requests_to_send.pop_front());
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result sink
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady_flow || ($urandom_range(0, 99) >= GAP_PERCENT);
      end
   end

   // monitor: predict on each request transaction, check each result transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            n_requests++;
            predict_coefficients(req_ch.coding_key, req_ch.coef_count);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_coefs++;
            if (rsp_ch.status != STATUS_OK) n_rejects++;
            if (coefs_due.size() == 0) begin
               $error("unexpected result: coefficient %0h last %0b status %0d",
                      rsp_ch.coefficient, rsp_ch.last, rsp_ch.status);
               errors_seen++;
            end else begin
               if (rsp_ch.coefficient !== coefs_due[0].coefficient) begin
                  $error("coefficient mismatch: expected %0h, got %0h",
                         coefs_due[0].coefficient, rsp_ch.coefficient);
                  errors_seen++;
               end
               if (rsp_ch.last !== coefs_due[0].last) begin
                  $error("last mismatch: expected %0b, got %0b",
                         coefs_due[0].last, rsp_ch.last);
                  errors_seen++;
               end
               if (rsp_ch.status !== coefs_due[0].status) begin
                  $error("status mismatch: expected %0d, got %0d",
                         coefs_due[0].status, rsp_ch.status);
                  errors_seen++;
               end
               void'(coefs_due.pop_front());
            end
         end
      end
   end

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {{(CSR_DATA_W-CFG_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_DENSITY) cfg_density = value;
      else cfg_degree = value;
   endtask

   task automatic apply_setting(input logic [CFG_W-1:0] density, input logic [CFG_W-1:0] degree);
      write_csr(ADDR_DENSITY, density);
      write_csr(ADDR_FIELD_DEGREE, degree);
      n_settings++;
      @(negedge clock);
   endtask

   task automatic send(input logic [KEY_W-1:0] key, input logic [COUNT_W-1:0] count);
      requests_to_send.push_back('{key, count});
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (requests_to_send.size() != 0 || req_ch.valid || coefs_due.size() != 0);
   endtask

   function automatic logic [COUNT_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 70) return COUNT_W'($urandom_range(1, 12));
      if (r < 90) return COUNT_W'($urandom_range(13, 40));
      if (r < 96) return COUNT_W'($urandom_range(41, 64));
      return COUNT_W'($urandom_range(65, 127));
   endfunction

   initial begin
      logic [CFG_W-1:0] dens;
      logic [CFG_W-1:0] deg;
      int               r;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: GF(2^8), full density
      send(16'h0000, 7'd1);
      send(16'hffff, 7'd64);
      send(16'h0001, 7'd65);
      send(16'h8000, 7'd127);
      send(16'h1234, 7'd0);
      send(16'haaaa, 7'd3);
      wait_drained();

      apply_setting(DENSITY_FULL, DEGREE_GF2);
      send(16'h5555, 7'd5);
      send(16'h0007, 7'd64);
      wait_drained();
      apply_setting(4'd0, DEGREE_GF2);
      send(16'hffff, 7'd20);
      send(16'h00ff, 7'd0);
      wait_drained();
      apply_setting(4'd0, DEGREE_GF256);
      send(16'hff00, 7'd16);
      wait_drained();
      apply_setting(4'd7, DEGREE_GF256);
      send(16'h2b3c, 7'd33);
      wait_drained();
      // bad degree wins over an empty window
      apply_setting(4'd3, 4'd0);
      send(16'h0102, 7'd0);
      send(16'h0304, 7'd5);
      wait_drained();
      apply_setting(DENSITY_FULL, 4'd15);
      send(16'hbeef, 7'd1);
      wait_drained();
      apply_setting(4'd9, 4'd9);
      send(16'h4321, 7'd127);
      wait_drained();

      for (int p = 0; p < RANDOM_SETTINGS; p++) begin
         case (p)
            0: begin dens = 4'd0;         deg = DEGREE_GF256; end
            1: begin dens = DENSITY_FULL; deg = DEGREE_GF2;   end
            2: begin dens = 4'd0;         deg = DEGREE_GF2;   end
            3: begin dens = DENSITY_FULL; deg = DEGREE_GF256; end
            4: begin dens = CFG_W'($urandom_range(0, 15)); deg = 4'd0;  end
            5: begin dens = CFG_W'($urandom_range(0, 15)); deg = 4'd15; end
            default: begin
               dens = CFG_W'($urandom_range(0, 15));
               r = $urandom_range(0, 99);
               if (r < 45) deg = DEGREE_GF256;
               else if (r < 80) deg = DEGREE_GF2;
               else deg = CFG_W'($urandom_range(0, 15));
            end
         endcase
         apply_setting(dens, deg);
         steady_flow = (p == 3);
         for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
            send(KEY_W'($urandom_range(0, 65535)), pick_count());
         end
         wait_drained();
         steady_flow = 1'b0;
      end

      repeat (END_QUIET_CYCLES) @(posedge clock);
      $display("summary: %0d requests under %0d register settings, %0d results checked",
               n_requests, n_settings, n_coefs);
      $display("summary: %0d error results (bad degree or empty window), %0d mismatches",
               n_rejects, errors_seen);
      if (errors_seen == 0 && coefs_due.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
